[hdl/cosim_pkg.sv]
// ----------------------------------------------------------------------------
// cosim_pkg
// Widths and types shared by the cosine similarity datapath and its root search.
// ----------------------------------------------------------------------------
package cosim_pkg;

    localparam int ELEM_W   = 16;            // one word count
    localparam int SQ_W     = 2 * ELEM_W;    // one element product
    localparam int ACC_W    = 38;            // saturating accumulators
    localparam int PROD_W   = 2 * ACC_W;     // product of two accumulators
    localparam int Q_W      = 16;            // Q1.15 similarity
    localparam int K_W      = $clog2(Q_W);   // bit index of the root search
    localparam int SCALE_SH = 2 * (Q_W - 1); // the 2^30 in q^2 * P <= R * 2^30
    localparam int ROOT_W   = PROD_W + SCALE_SH + 4;

    typedef logic [ACC_W-1:0]  t_acc;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [ROOT_W-1:0] t_root;

    localparam t_acc ACC_MAX = {ACC_W{1'b1}};

endpackage

[hdl/cosim_root.sv]
// ----------------------------------------------------------------------------
// cosim_root
// Bit-by-bit search for the largest q <= 2^15 with q^2 * P <= R * 2^30.
// ----------------------------------------------------------------------------
module cosim_root
    import cosim_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  t_prod          i_p,
    input  t_prod          i_r,
    output logic           o_done,
    output logic [Q_W-1:0] o_q
);

    localparam logic [1:0] RS_IDLE = 2'd0;
    localparam logic [1:0] RS_SUM  = 2'd1;
    localparam logic [1:0] RS_ADD  = 2'd2;
    localparam logic [1:0] RS_TEST = 2'd3;

    logic [1:0]     r_state;
    logic           r_done;
    logic [K_W-1:0] r_k;
    logic [Q_W-1:0] r_q;
    logic           r_top;
    t_root          r_t;
    t_root          r_us;
    t_root          r_ps;
    t_root          r_x;
    t_root          r_y;
    t_root          r_r30;
    logic           fits;

    // With q built from the bits above k, r_t holds q^2*P, r_us holds
    // (q*P) << (k+1) and r_ps holds P << 2k, so the candidate q + 2^k
    // squared times P is their sum. Once the top bit is taken, q is at
    // its ceiling and no lower bit may be added.
    assign fits = (r_x <= r_r30) && !r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                RS_IDLE: begin
                    if (i_start) begin
                        r_state <= RS_SUM;
                    end
                end
                RS_SUM:  r_state <= RS_ADD;
                RS_ADD:  r_state <= RS_TEST;
                RS_TEST: begin
                    if (r_k == '0) begin
                        r_state <= RS_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= RS_SUM;
                    end
                end
                default: r_state <= RS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            RS_IDLE: begin
                if (i_start) begin
                    r_t   <= '0;
                    r_us  <= '0;
                    r_ps  <= ROOT_W'({i_p, {SCALE_SH{1'b0}}});
                    r_r30 <= ROOT_W'({i_r, {SCALE_SH{1'b0}}});
                    r_q   <= '0;
                    r_top <= 1'b0;
                    r_k   <= K_W'(Q_W - 1);
                end
            end
            RS_SUM: begin
                r_x <= r_t + r_us;
                r_y <= r_us + (r_ps << 1);
            end
            RS_ADD: begin
                r_x <= r_x + r_ps;
            end
            RS_TEST: begin
                if (fits) begin
                    r_t      <= r_x;
                    r_us     <= r_y >> 1;
                    r_q[r_k] <= 1'b1;
                    if (r_k == K_W'(Q_W - 1)) begin
                        r_top <= 1'b1;
                    end
                end else begin
                    r_us <= r_us >> 1;
                end
                r_ps <= r_ps >> 2;
                r_k  <= r_k - 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_q    = r_q;

`ifndef NO_ASSERTIONS
    a_q_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_q <= Q_W'(1 << (Q_W - 1))))
        else $error("root result above one");

    a_top_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == RS_TEST && r_top) |-> (r_q == Q_W'(1 << (Q_W - 1))))
        else $error("bits set below a full-scale root");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == RS_IDLE))
        else $error("root done while still searching");
`endif

endmodule

[hdl/cosine_similarity_unit.sv]
// ----------------------------------------------------------------------------
// cosine_similarity_unit
// Streaming cosine similarity of two word-count vectors, one element pair per
// word. After accepting an element pair the unit is not ready again until it is
// done with it: a bit-serial shift-add multiplier forms the three products, one
// multiplier bit per cycle, and the ACC state then adds them into the saturating
// accumulators. On the last pair the unit then forms sumsq_a*sumsq_b and dot^2
// bit-serially and runs a 16-step root search (skipped when either vector is all
// zero), posts the result word once the output register is free, and returns to
// idle for the next pair. The result sits in an output register, so the next
// vector can start while it waits.
// Similarity is the truncated Q1.15 value of dot / (|a| * |b|); a zero norm
// gives 0 with o_zero_norm set.
// ----------------------------------------------------------------------------
module cosine_similarity_unit
    import cosim_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ELEM_W-1:0] i_elem_a,
    input  logic [ELEM_W-1:0] i_elem_b,
    input  logic              i_last_elem,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [Q_W-1:0]    o_similarity,
    output logic              o_zero_norm
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_ACC    = 3'd2;
    localparam logic [2:0] ST_PROD   = 3'd3;
    localparam logic [2:0] ST_RSTART = 3'd4;
    localparam logic [2:0] ST_ROOT   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    localparam int CNT_W = $clog2(ACC_W);

    function automatic t_acc sat_add(input t_acc acc, input logic [SQ_W-1:0] v);
        logic [ACC_W:0] s;
        s = {1'b0, acc} + (ACC_W + 1)'(v);
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_last;
    logic              r_zero;
    logic [ELEM_W-1:0] r_a;
    logic [ELEM_W-1:0] r_b;
    logic [ELEM_W-1:0] r_sa;
    logic [ELEM_W-1:0] r_sb;
    logic [SQ_W-1:0]   r_pab;
    logic [SQ_W-1:0]   r_paa;
    logic [SQ_W-1:0]   r_pbb;
    t_acc              r_dot;
    t_acc              r_sumsq_a;
    t_acc              r_sumsq_b;
    t_acc              r_mp;
    t_acc              r_md;
    t_prod             r_p;
    t_prod             r_r;
    logic              r_o_valid;
    logic [Q_W-1:0]    r_o_sim;
    logic              r_o_zero;

    t_acc              n_dot;
    t_acc              n_sumsq_a;
    t_acc              n_sumsq_b;
    logic              slot_free;
    logic              post;
    logic              root_done;
    logic [Q_W-1:0]    root_q;

    assign n_dot     = sat_add(r_dot, r_pab);
    assign n_sumsq_a = sat_add(r_sumsq_a, r_paa);
    assign n_sumsq_b = sat_add(r_sumsq_b, r_pbb);

    assign slot_free = !r_o_valid || i_ready;
    assign post      = (r_state == ST_DONE) && slot_free;

    // Control and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_dot     <= '0;
            r_sumsq_a <= '0;
            r_sumsq_b <= '0;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_cnt == CNT_W'(ELEM_W - 1)) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_dot     <= n_dot;
                    r_sumsq_a <= n_sumsq_a;
                    r_sumsq_b <= n_sumsq_b;
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (n_sumsq_a == '0 || n_sumsq_b == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    if (r_cnt == CNT_W'(ACC_W - 1)) begin
                        r_state <= ST_RSTART;
                    end
                end
                ST_RSTART: r_state <= ST_ROOT;
                ST_ROOT: begin
                    if (root_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (slot_free) begin
                        r_state   <= ST_IDLE;
                        r_dot     <= '0;
                        r_sumsq_a <= '0;
                        r_sumsq_b <= '0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (post) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Serial multipliers: one multiplier bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_a    <= i_elem_a;
                    r_b    <= i_elem_b;
                    r_sa   <= i_elem_a;
                    r_sb   <= i_elem_b;
                    r_last <= i_last_elem;
                    r_pab  <= '0;
                    r_paa  <= '0;
                    r_pbb  <= '0;
                    r_cnt  <= '0;
                end
            end
            ST_MUL: begin
                r_pab <= (r_pab << 1) + (r_sa[ELEM_W-1] ? SQ_W'(r_b) : '0);
                r_paa <= (r_paa << 1) + (r_sa[ELEM_W-1] ? SQ_W'(r_a) : '0);
                r_pbb <= (r_pbb << 1) + (r_sb[ELEM_W-1] ? SQ_W'(r_b) : '0);
                r_sa  <= r_sa << 1;
                r_sb  <= r_sb << 1;
                r_cnt <= r_cnt + 1'b1;
            end
            ST_ACC: begin
                r_zero <= (n_sumsq_a == '0) || (n_sumsq_b == '0);
                r_mp   <= n_sumsq_b;
                r_md   <= n_dot;
                r_p    <= '0;
                r_r    <= '0;
                r_cnt  <= '0;
            end
            ST_PROD: begin
                r_p   <= (r_p << 1) + (r_mp[ACC_W-1] ? PROD_W'(r_sumsq_a) : '0);
                r_r   <= (r_r << 1) + (r_md[ACC_W-1] ? PROD_W'(r_dot) : '0);
                r_mp  <= r_mp << 1;
                r_md  <= r_md << 1;
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase

        if (post) begin
            r_o_sim  <= r_zero ? '0 : root_q;
            r_o_zero <= r_zero;
        end
    end

    cosim_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_RSTART),
        .i_p     (r_p),
        .i_r     (r_r),
        .o_done  (root_done),
        .o_q     (root_q)
    );

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_o_valid;
    assign o_similarity = r_o_sim;
    assign o_zero_norm  = r_o_zero;

`ifndef NO_ASSERTIONS
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        post |=> (r_dot == '0 && r_sumsq_a == '0 && r_sumsq_b == '0))
        else $error("accumulators not cleared after a vector end");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_norm) |-> (o_similarity == '0))
        else $error("zero norm word with nonzero similarity");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_similarity <= Q_W'(1 << (Q_W - 1))))
        else $error("similarity above one");

    a_root_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_done |-> (r_state == ST_ROOT))
        else $error("root search finished outside its wait state");
`endif

endmodule
